FILE: design/ste_pkg.sv
`default_nettype none

package ste_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam int IDENT_LEN  = 16;
    localparam int STATUS_IDX = 16;
    localparam int GUARD_A    = 19;
    localparam int GUARD_B    = 22;
    localparam int GUARD_C    = 25;
    localparam int MIN_SIZE   = 28;
    localparam int UDU_TYPE   = 5;

    localparam logic [4:0] H264_SEI_TYPE = 5'd6;
    localparam logic [5:0] H265_SEI_TYPE = 6'd39;
    localparam logic [7:0] EXT_BYTE      = 8'hff;
    localparam logic [7:0] GUARD_BYTE    = 8'hff;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    localparam logic [7:0] IDENT_TAB [0:1][0:15] = '{
        '{8'h4d, 8'h49, 8'h53, 8'h50, 8'h6d, 8'h69, 8'h63, 8'h72,
          8'h6f, 8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6d, 8'h65},
        '{8'ha8, 8'h68, 8'h7d, 8'hd4, 8'hd7, 8'h59, 8'h37, 8'h58,
          8'ha5, 8'hce, 8'hf0, 8'h33, 8'h8b, 8'h65, 8'h45, 8'hf1}
    };

    typedef enum logic [1:0] {
        RC_FOUND = 2'd0,
        RC_NONE  = 2'd1,
        RC_GUARD = 2'd2
    } rc_t;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_SIZE    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // packed so that result_code sits in the lowest bits
    typedef struct packed {
        logic [63:0] timestamp_us;
        logic [7:0]  time_status;
        rc_t         result_code;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int RESULT_BYTES_BITS = ((RESULT_BITS + 7) / 8) * 8;

    function automatic logic [7:0] ident_byte(input logic codec, input logic [3:0] idx);
        return IDENT_TAB[codec][idx];
    endfunction

endpackage

`default_nettype wire

FILE: design/ste_parser.sv
`default_nettype none

module ste_parser
    import ste_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       codec,
    input  wire logic       in_accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            res_valid,
    output result_t         res
);

    localparam logic [LENGTH_BITS-1:0] L_IDENT  = LENGTH_BITS'(IDENT_LEN);
    localparam logic [LENGTH_BITS-1:0] L_STATUS = LENGTH_BITS'(STATUS_IDX);
    localparam logic [LENGTH_BITS-1:0] L_GA     = LENGTH_BITS'(GUARD_A);
    localparam logic [LENGTH_BITS-1:0] L_GB     = LENGTH_BITS'(GUARD_B);
    localparam logic [LENGTH_BITS-1:0] L_GC     = LENGTH_BITS'(GUARD_C);
    localparam logic [LENGTH_BITS-1:0] L_MIN    = LENGTH_BITS'(MIN_SIZE);
    localparam logic [LENGTH_BITS-1:0] L_UDU    = LENGTH_BITS'(UDU_TYPE);

    phase_t                 phase_reg, phase_next;
    logic                   header_count_reg, header_count_next;
    logic [LENGTH_BITS-1:0] type_sum_reg, type_sum_next;
    logic [LENGTH_BITS-1:0] size_sum_reg, size_sum_next;
    logic [LENGTH_BITS-1:0] payload_count_reg, payload_count_next;
    logic                   ident_match_reg, ident_match_next;
    logic                   guards_ok_reg, guards_ok_next;
    logic [7:0]             status_reg, status_next;
    logic [63:0]            stamp_reg, stamp_next;
    rc_t                    verdict_reg, verdict_next;

    logic [LENGTH_BITS-1:0] type_add;
    logic [LENGTH_BITS-1:0] size_add;
    logic [LENGTH_BITS-1:0] count_inc;

    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                        input logic [7:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {{(LENGTH_BITS-7){1'b0}}, b};
        return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
    endfunction

    assign type_add  = sat_add(type_sum_reg, in_byte);
    assign size_add  = sat_add(size_sum_reg, in_byte);
    assign count_inc = payload_count_reg + LENGTH_BITS'(1);

    always_comb begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        type_sum_next      = type_sum_reg;
        size_sum_next      = size_sum_reg;
        payload_count_next = payload_count_reg;
        ident_match_next   = ident_match_reg;
        guards_ok_next     = guards_ok_reg;
        status_next        = status_reg;
        stamp_next         = stamp_reg;
        verdict_next       = verdict_reg;

        case (phase_reg)
            PH_HEADER: begin
                if (header_count_reg) begin
                    phase_next    = PH_TYPE;
                    type_sum_next = '0;
                    size_sum_next = '0;
                end else if (codec == CODEC_H264) begin
                    if (in_byte[4:0] == H264_SEI_TYPE) begin
                        phase_next    = PH_TYPE;
                        type_sum_next = '0;
                        size_sum_next = '0;
                    end else begin
                        verdict_next = RC_NONE;
                        phase_next   = PH_DONE;
                    end
                end else begin
                    if (in_byte[6:1] == H265_SEI_TYPE) begin
                        header_count_next = 1'b1;
                    end else begin
                        verdict_next = RC_NONE;
                        phase_next   = PH_DONE;
                    end
                end
            end
            PH_TYPE: begin
                type_sum_next = type_add;
                if (in_byte != EXT_BYTE) begin
                    size_sum_next = '0;
                    phase_next    = PH_SIZE;
                end
            end
            PH_SIZE: begin
                size_sum_next = size_add;
                if (in_byte != EXT_BYTE) begin
                    if (size_add == '0) begin
                        phase_next    = PH_TYPE;
                        type_sum_next = '0;
                    end else begin
                        phase_next         = PH_PAYLOAD;
                        payload_count_next = '0;
                        ident_match_next   = 1'b1;
                        guards_ok_next     = 1'b1;
                        status_next        = '0;
                        stamp_next         = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (payload_count_reg < L_IDENT) begin
                    if (in_byte != ident_byte(codec, payload_count_reg[3:0])) begin
                        ident_match_next = 1'b0;
                    end
                end else if (payload_count_reg == L_STATUS) begin
                    status_next = in_byte;
                end else if (payload_count_reg == L_GA || payload_count_reg == L_GB ||
                             payload_count_reg == L_GC) begin
                    if (in_byte != GUARD_BYTE) begin
                        guards_ok_next = 1'b0;
                    end
                end else if (payload_count_reg < L_MIN) begin
                    stamp_next = {stamp_reg[55:0], in_byte};
                end
                payload_count_next = count_inc;
                if (count_inc >= size_sum_reg) begin
                    if (type_sum_reg == L_UDU && size_sum_reg >= L_MIN && ident_match_next) begin
                        verdict_next = guards_ok_next ? RC_FOUND : RC_GUARD;
                        phase_next   = PH_DONE;
                    end else begin
                        phase_next    = PH_TYPE;
                        type_sum_next = '0;
                        size_sum_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_valid        = in_accept && in_last;
        res.result_code  = RC_NONE;
        res.time_status  = '0;
        res.timestamp_us = '0;
        if (phase_next == PH_DONE && verdict_next == RC_FOUND) begin
            res.result_code  = RC_FOUND;
            res.time_status  = status_next;
            res.timestamp_us = stamp_next;
        end else if (phase_next == PH_DONE && verdict_next == RC_GUARD) begin
            res.result_code = RC_GUARD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 1'b0;
            type_sum_reg      <= '0;
            size_sum_reg      <= '0;
            payload_count_reg <= '0;
            ident_match_reg   <= 1'b1;
            guards_ok_reg     <= 1'b1;
            verdict_reg       <= RC_NONE;
        end else if (in_accept) begin
            if (in_last) begin
                phase_reg         <= PH_HEADER;
                header_count_reg  <= 1'b0;
                type_sum_reg      <= '0;
                size_sum_reg      <= '0;
                payload_count_reg <= '0;
                ident_match_reg   <= 1'b1;
                guards_ok_reg     <= 1'b1;
                verdict_reg       <= RC_NONE;
            end else begin
                phase_reg         <= phase_next;
                header_count_reg  <= header_count_next;
                type_sum_reg      <= type_sum_next;
                size_sum_reg      <= size_sum_next;
                payload_count_reg <= payload_count_next;
                ident_match_reg   <= ident_match_next;
                guards_ok_reg     <= guards_ok_next;
                verdict_reg       <= verdict_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            status_reg <= status_next;
            stamp_reg  <= stamp_next;
        end
    end

    // payload walk never runs past the declared size
    a_count_in_size: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> payload_count_reg < size_sum_reg)
        else $error("payload count beyond declared size");

    // every unit ends with the parser back at the header
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_last |=> phase_reg == PH_HEADER && !header_count_reg)
        else $error("parser not restarted after last byte");

    // second header byte is skipped, moving the parser on to the type phase
    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg && phase_reg == PH_HEADER && in_accept && !in_last
        |=> phase_reg == PH_TYPE)
        else $error("second header byte not skipped");

endmodule

`default_nettype wire

FILE: design/ste_out_buf.sv
`default_nettype none

module ste_out_buf
    import ste_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire result_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    main_free;
    logic    push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    // skid stage only holds a transaction behind a full output register
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid full with output register empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ready && in_valid))
        else $error("skid filled without a stall");

endmodule

`default_nettype wire

FILE: design/sei_timestamp_extractor.sv
`default_nettype none
// output: a result enters the output register when its last byte is accepted,
// or the skid stage while the output register holds an earlier undelivered result
// throughput: one byte per cycle; s_tready drops only while both the output
// register and the skid stage hold undelivered results
// reset: aresetn synchronous, active low; parser returns to the header phase,
// output stages empty, codec_select cleared to H.264

module sei_timestamp_extractor
    import ste_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_data,    // codec_select
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,     // nal_byte
    input  wire logic                         s_tlast,     // last_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // result_code [1:0], time_status [9:2], timestamp_us [73:10]
    output logic [RESULT_BYTES_BITS-1:0]      m_tdata
);

    logic    codec_reg;
    logic    in_accept;
    logic    res_valid;
    logic    buf_ready;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_ready;
    assign in_accept = s_tvalid && buf_ready;
    assign m_tdata   = {{(RESULT_BYTES_BITS-RESULT_BITS){1'b0}}, out_res};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= CODEC_H264;
        end else if (cfg_valid && cfg_ready) begin
            codec_reg <= cfg_data;
        end
    end

    ste_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .codec     (codec_reg),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    ste_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

endmodule

`default_nettype wire
